/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent check wrappers, compiled out under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check on every rising edge, off while reset is held
`define SC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("check failed");
// check on every rising edge, reset included
`define SC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("check failed");
`else
`define SC_ASSERT(lbl, clk, rst_n, prop)
`define SC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* hdl/sc8fp_pkg.sv */
// ----------------------------------------------------------------------------
// sc8fp_pkg
// types and constants of the command frame parser
// ----------------------------------------------------------------------------
`default_nettype none

package sc8fp_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int STORE_AW    = 6;

    // length bytes at or above this value drop the frame
    localparam logic [7:0] LENGTH_LIMIT = 8'd50;

    localparam logic [7:0] HDR_FIRST   = 8'hAA;
    localparam logic [7:0] HDR_SECOND  = 8'hAF;
    localparam logic [7:0] FUNC_LIMIT  = 8'hF1;

    localparam logic [7:0] CMD_LOCK    = 8'h01;
    localparam logic [7:0] CMD_ENABLE  = 8'h03;
    localparam logic [7:0] CMD_GAIN_A  = 8'h10;
    localparam logic [7:0] CMD_GAIN_B  = 8'h11;

    // lock commands are 0xa0..0xa3
    localparam logic [7:0] LOCK_CODE_BASE = 8'hA0;

    localparam logic [3:0] ENABLE_LAST = 4'd10;
    localparam logic [3:0] GAIN_A_LAST = 4'd8;
    localparam logic [3:0] GAIN_B_LAST = 4'd2;

    typedef enum logic [2:0] {
        KIND_LOCK_ON   = 3'd0,
        KIND_LOCK_OFF  = 3'd1,
        KIND_SET_UPLD  = 3'd2,
        KIND_GAIN_UPLD = 3'd3,
        KIND_ENABLE    = 3'd4,
        KIND_GAIN_A    = 3'd5,
        KIND_GAIN_B    = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_SYNC = 3'd1,
        PH_FUNC = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_SUM  = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        E_IDLE = 2'd0,
        E_REQ  = 2'd1,
        E_HI   = 2'd2,
        E_PUT  = 2'd3
    } t_emit_state;

    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
    } t_wr;

    typedef struct packed {
        logic       go;
        logic [7:0] func;
    } t_frame;

endpackage

`default_nettype wire

/* hdl/sc8fp_ram.sv */
// ----------------------------------------------------------------------------
// sc8fp_ram
// generic simple dual port ram, one write port, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module sc8fp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hdl/sc8fp_store.sv */
// ----------------------------------------------------------------------------
// sc8fp_store
// payload store: ram plus per-entry written flags, unwritten entries read zero
// ----------------------------------------------------------------------------
`default_nettype none

module sc8fp_store
    import sc8fp_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_wr                 i_wr,
    input  wire logic                i_re,
    input  wire logic [STORE_AW-1:0] i_raddr,
    output logic      [7:0]          o_rdata
);

    logic [STORE_DEPTH-1:0] r_written;
    logic                   r_rd_written;
    logic [7:0]             ram_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_wr.we) begin
                r_written[i_wr.addr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_written <= r_written[i_raddr];
            end
        end
    end

    sc8fp_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.we),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.data),
        .i_re    (i_re),
        .i_raddr (i_raddr),
        .o_rdata (ram_q)
    );

    assign o_rdata = r_rd_written ? ram_q : 8'h00;

endmodule

`default_nettype wire

/* hdl/sc8fp_parse.sv */
// ----------------------------------------------------------------------------
// sc8fp_parse
// byte-level frame parser: header, function, length, payload, sum check
// ----------------------------------------------------------------------------
`default_nettype none

module sc8fp_parse
    import sc8fp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_byte,
    output t_wr             o_wr,
    output t_frame          o_frame
);

    t_phase              r_phase, n_phase;
    logic [7:0]          r_func,  n_func;
    logic [5:0]          r_left,  n_left;
    logic [STORE_AW-1:0] r_count, n_count;
    logic [7:0]          r_sum,   n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_func  <= '0;
            r_left  <= '0;
            r_count <= '0;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            r_func  <= n_func;
            r_left  <= n_left;
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_func       = r_func;
        n_left       = r_left;
        n_count      = r_count;
        n_sum        = r_sum;
        o_wr.we      = 1'b0;
        o_wr.addr    = r_count;
        o_wr.data    = i_byte;
        o_frame.go   = 1'b0;
        o_frame.func = r_func;
        if (i_accept) begin
            unique case (r_phase)
                PH_SYNC: begin
                    if (i_byte == HDR_SECOND) begin
                        n_phase = PH_FUNC;
                        n_sum   = r_sum + i_byte;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_FUNC: begin
                    if (i_byte != 8'h00 && i_byte < FUNC_LIMIT) begin
                        n_phase = PH_LEN;
                        n_func  = i_byte;
                        n_sum   = r_sum + i_byte;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_LEN: begin
                    if (i_byte < LENGTH_LIMIT) begin
                        n_phase = PH_DATA;
                        n_left  = i_byte[5:0];
                        n_count = '0;
                        n_sum   = r_sum + i_byte;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_DATA: begin
                    if (r_left != 6'd0) begin
                        o_wr.we = 1'b1;
                        n_count = r_count + 1'b1;
                        n_left  = r_left - 1'b1;
                        n_sum   = r_sum + i_byte;
                        if (r_left == 6'd1) begin
                            n_phase = PH_SUM;
                        end
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_SUM: begin
                    n_phase    = PH_HUNT;
                    o_frame.go = (r_sum == i_byte);
                end
                default: begin
                    if (i_byte == HDR_FIRST) begin
                        n_phase = PH_SYNC;
                        n_sum   = i_byte;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* hdl/sc8fp_emit.sv */
// ----------------------------------------------------------------------------
// sc8fp_emit
// frame decoder: walks the payload store and drives the result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sc8fp_emit
    import sc8fp_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_frame              i_frame,
    input  wire logic [7:0]          i_rdata,
    output logic                     o_re,
    output logic      [STORE_AW-1:0] o_raddr,
    output logic                     o_busy,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic      [2:0]          o_kind,
    output logic      [3:0]          o_item_index,
    output logic      [15:0]         o_item_value,
    output logic                     o_last
);

    t_emit_state r_state, n_state;
    logic [7:0]  r_func,  n_func;
    logic [3:0]  r_idx,   n_idx;
    logic [7:0]  r_hi,    n_hi;

    logic        r_out_valid;
    t_kind       r_kind;
    logic [3:0]  r_index;
    logic [15:0] r_value;
    logic        r_last;

    logic        is_gain;
    logic [3:0]  final_idx;
    logic        out_free;
    logic        load;
    logic        put_last;
    t_kind       put_kind;
    logic [15:0] put_value;
    logic [7:0]  lock_off;

    assign is_gain  = (r_func == CMD_GAIN_A) || (r_func == CMD_GAIN_B);
    assign out_free = !r_out_valid || !i_out_stall;
    assign put_last = (r_idx == final_idx);
    assign lock_off = i_rdata - LOCK_CODE_BASE;

    always_comb begin
        unique case (r_func)
            CMD_ENABLE: final_idx = ENABLE_LAST;
            CMD_GAIN_A: final_idx = GAIN_A_LAST;
            CMD_GAIN_B: final_idx = GAIN_B_LAST;
            default:    final_idx = 4'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= E_IDLE;
            r_func      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_func  <= n_func;
            r_idx   <= n_idx;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi <= n_hi;
        if (load) begin
            r_kind  <= put_kind;
            r_index <= r_idx;
            r_value <= put_value;
            r_last  <= put_last;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_idx     = r_idx;
        n_hi      = r_hi;
        o_re      = 1'b0;
        o_raddr   = {2'b00, r_idx};
        load      = 1'b0;
        put_kind  = KIND_ENABLE;
        put_value = {8'h00, i_rdata};
        unique case (r_state)
            E_IDLE: begin
                if (i_frame.go) begin
                    n_func = i_frame.func;
                    n_idx  = '0;
                    if (i_frame.func == CMD_LOCK || i_frame.func == CMD_ENABLE ||
                        i_frame.func == CMD_GAIN_A || i_frame.func == CMD_GAIN_B) begin
                        n_state = E_REQ;
                    end
                end
            end
            E_REQ: begin
                o_re = 1'b1;
                if (is_gain) begin
                    o_raddr = {1'b0, r_idx, 1'b0};
                    n_state = E_HI;
                end else begin
                    n_state = E_PUT;
                end
            end
            E_HI: begin
                // high byte present, fetch the low byte
                n_hi    = i_rdata;
                o_re    = 1'b1;
                o_raddr = {1'b0, r_idx, 1'b1};
                n_state = E_PUT;
            end
            E_PUT: begin
                if (r_func == CMD_LOCK) begin
                    put_kind  = t_kind'(lock_off[2:0]);
                    put_value = '0;
                end else if (r_func == CMD_GAIN_A) begin
                    put_kind  = KIND_GAIN_A;
                    put_value = {r_hi, i_rdata};
                end else if (r_func == CMD_GAIN_B) begin
                    put_kind  = KIND_GAIN_B;
                    put_value = {r_hi, i_rdata};
                end
                if (r_func == CMD_LOCK && i_rdata[7:2] != LOCK_CODE_BASE[7:2]) begin
                    // unknown lock code, frame gives nothing
                    n_state = E_IDLE;
                end else if (out_free) begin
                    load = 1'b1;
                    if (put_last) begin
                        n_state = E_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = E_REQ;
                    end
                end
            end
            default: n_state = E_IDLE;
        endcase
    end

    assign o_busy       = (r_state != E_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_item_index = r_index;
    assign o_item_value = r_value;
    assign o_last       = r_last;

    `SC_ASSERT(a_go_only_idle, i_clk, i_rst_n, i_frame.go |-> (r_state == E_IDLE))
    `SC_ASSERT(a_no_read_idle, i_clk, i_rst_n, (r_state == E_IDLE) |-> !o_re)
    `SC_ASSERT(a_last_ends, i_clk, i_rst_n, (load && put_last) |=> (r_state == E_IDLE))

endmodule

`default_nettype wire

/* hdl/sum8_command_frame_parser_top.sv */
// ----------------------------------------------------------------------------
// sum8_command_frame_parser_top
// header/length/sum8 command frame parser with decoded result stream
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  ---------------------------------
//  in       sink       i_in_valid / o_in_stall    i_rx_byte
//  out      source     o_out_valid / i_out_stall  o_kind o_item_index
//                                                 o_item_value o_last
//
//  a header, length or payload byte is one cycle per transfer
//  after the closing sum byte of a good lock, enable or gain frame the input is
//  stalled for the decode walk, which reads the single store read port once
//  per enable or lock result, twice per gain result, and waits on output stall
//  the last result sits in the output register while the next bytes flow in
//  reset is synchronous, active low; no clearing pass, the store reads zero
//  for entries never written thanks to per-entry written flags
// ----------------------------------------------------------------------------
`default_nettype none

module sum8_command_frame_parser_top
    import sc8fp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // byte input
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic        [7:0]  i_rx_byte,
    // result output
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic             [2:0]  o_kind,
    output logic             [3:0]  o_item_index,
    output logic signed      [15:0] o_item_value,
    output logic                    o_last
);

    logic                in_accept;
    logic                busy;
    t_wr                 wr;
    t_frame              frame;
    logic                rd_en;
    logic [STORE_AW-1:0] rd_addr;
    logic [7:0]          rd_data;
    logic [15:0]         value;

    // input is held off while the decoder walks the store
    assign o_in_stall = busy;
    assign in_accept  = i_in_valid && !o_in_stall;

    // parser: phase, function, counters and running sum; writes payload bytes
    sc8fp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_rx_byte),
        .o_wr     (wr),
        .o_frame  (frame)
    );

    // payload store, one write port from the parser, one read port to the decoder
    sc8fp_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // decoder: starts on a good sum byte of a lock, enable or gain frame, emits each result transfer
    sc8fp_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frame      (frame),
        .i_rdata      (rd_data),
        .o_re         (rd_en),
        .o_raddr      (rd_addr),
        .o_busy       (busy),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_item_index (o_item_index),
        .o_item_value (value),
        .o_last       (o_last)
    );

    assign o_item_value = $signed(value);

endmodule

`default_nettype wire

/* verif/sum8_command_frame_parser_top_test.sv */
// ----------------------------------------------------------------------------
// sum8_command_frame_parser_top_test
// self-checking bench: byte frames in, decoded command results out, each
// result compared with a bit-exact software copy of the frame parser
// ----------------------------------------------------------------------------
`default_nettype none

module sum8_command_frame_parser_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sc8fp_pkg::*;

    // run limits
    localparam int TIMEOUT_NS    = 20_000_000;
    localparam int RANDOM_ITEMS  = 330;
    localparam int DRAIN_CYCLES  = 64;
    localparam int REPORT_LIMIT  = 10;
    localparam int LOCK_CODES    = 4;

    // one decoded result as it leaves the block
    typedef struct packed {
        t_kind              kind;
        logic [3:0]         idx;
        logic signed [15:0] value;
        logic               last;
    } t_cmd_result;

    // how a table row gets its byte
    typedef enum logic [1:0] {
        ROW_BYTE     = 2'd0,
        ROW_SUM_GOOD = 2'd1,
        ROW_SUM_BAD  = 2'd2
    } t_row_kind;

    typedef struct packed {
        t_row_kind   what;
        logic [7:0]  data;
        logic        fixed_want;
        t_cmd_result want;
    } t_stim_row;

    localparam t_cmd_result NO_RESULT = '{KIND_LOCK_ON, 4'd0, 16'sd0, 1'b0};
    localparam t_cmd_result LOCK_ON_RESULT = '{KIND_LOCK_ON, 4'd0, 16'sd0, 1'b1};

    // directed frames; good sum rows take the running sum of the frame so far, bad ones its inverse
    localparam t_stim_row DIRECTED_ROWS [0:39] = '{
        // lock on, result typed in
        '{ROW_BYTE,     HDR_FIRST,      1'b0, NO_RESULT},
        '{ROW_BYTE,     HDR_SECOND,     1'b0, NO_RESULT},
        '{ROW_BYTE,     CMD_LOCK,       1'b0, NO_RESULT},
        '{ROW_BYTE,     8'h01,          1'b0, NO_RESULT},
        '{ROW_BYTE,     LOCK_CODE_BASE, 1'b0, NO_RESULT},
        '{ROW_SUM_GOOD, 8'h00,          1'b1, LOCK_ON_RESULT},
        // repeated first header byte drops to the hunt, the second is then ignored
        '{ROW_BYTE,     HDR_FIRST,      1'b0, NO_RESULT},
        '{ROW_BYTE,     HDR_FIRST,      1'b0, NO_RESULT},
        '{ROW_BYTE,     HDR_SECOND,     1'b0, NO_RESULT},
        // function code zero
        '{ROW_BYTE,     HDR_FIRST,      1'b0, NO_RESULT},
        '{ROW_BYTE,     HDR_SECOND,     1'b0, NO_RESULT},
        '{ROW_BYTE,     8'h00,          1'b0, NO_RESULT},
        // zero length swallows the next byte
        '{ROW_BYTE,     HDR_FIRST,      1'b0, NO_RESULT},
        '{ROW_BYTE,     HDR_SECOND,     1'b0, NO_RESULT},
        '{ROW_BYTE,     CMD_ENABLE,     1'b0, NO_RESULT},
        '{ROW_BYTE,     8'h00,          1'b0, NO_RESULT},
        '{ROW_BYTE,     8'hFF,          1'b0, NO_RESULT},
        // length at the limit
        '{ROW_BYTE,     HDR_FIRST,      1'b0, NO_RESULT},
        '{ROW_BYTE,     HDR_SECOND,     1'b0, NO_RESULT},
        '{ROW_BYTE,     CMD_GAIN_A,     1'b0, NO_RESULT},
        '{ROW_BYTE,     LENGTH_LIMIT,   1'b0, NO_RESULT},
        // bad sum, payload still lands in the store
        '{ROW_BYTE,     HDR_FIRST,      1'b0, NO_RESULT},
        '{ROW_BYTE,     HDR_SECOND,     1'b0, NO_RESULT},
        '{ROW_BYTE,     CMD_GAIN_B,     1'b0, NO_RESULT},
        '{ROW_BYTE,     8'h02,          1'b0, NO_RESULT},
        '{ROW_BYTE,     8'h80,          1'b0, NO_RESULT},
        '{ROW_BYTE,     8'h00,          1'b0, NO_RESULT},
        '{ROW_SUM_BAD,  8'h00,          1'b0, NO_RESULT},
        // short gain frame, later gains read stale entries
        '{ROW_BYTE,     HDR_FIRST,      1'b0, NO_RESULT},
        '{ROW_BYTE,     HDR_SECOND,     1'b0, NO_RESULT},
        '{ROW_BYTE,     CMD_GAIN_B,     1'b0, NO_RESULT},
        '{ROW_BYTE,     8'h01,          1'b0, NO_RESULT},
        '{ROW_BYTE,     8'hFF,          1'b0, NO_RESULT},
        '{ROW_SUM_GOOD, 8'h00,          1'b0, NO_RESULT},
        // short enable frame
        '{ROW_BYTE,     HDR_FIRST,      1'b0, NO_RESULT},
        '{ROW_BYTE,     HDR_SECOND,     1'b0, NO_RESULT},
        '{ROW_BYTE,     CMD_ENABLE,     1'b0, NO_RESULT},
        '{ROW_BYTE,     8'h01,          1'b0, NO_RESULT},
        '{ROW_BYTE,     8'h00,          1'b0, NO_RESULT},
        '{ROW_SUM_GOOD, 8'h00,          1'b0, NO_RESULT}
    };

    // block ports
    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    logic        [7:0]  i_rx_byte   = 8'h00;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic        [2:0]  o_kind;
    logic        [3:0]  o_item_index;
    logic signed [15:0] o_item_value;
    logic               o_last;

    sum8_command_frame_parser_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_item_index (o_item_index),
        .o_item_value (o_item_value),
        .o_last       (o_last)
    );

    // 50 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hard stop if the block hangs
    initial begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // parser copy: phase, command, counters, running sum and payload store
    t_phase      phase_m;
    logic [7:0]  func_m;
    logic [5:0]  left_m;
    logic [5:0]  count_m;
    logic [7:0]  sum_m;
    logic [7:0]  store_m [STORE_DEPTH];

    // results still owed by the block, oldest first
    t_cmd_result due_results [$];
    t_cmd_result seen_result;

    int  error_count;
    int  n_frame_items;
    bit  no_idle;

    function automatic void due_result(input t_kind kind, input logic [3:0] idx,
                                       input logic [15:0] value, input logic last);
        t_cmd_result r;
        r.kind  = kind;
        r.idx   = idx;
        r.value = value;
        r.last  = last;
        due_results.push_back(r);
    endfunction

    // advance the parser copy by one byte, queue whatever a good frame decodes to
    function automatic void decode_rx_byte(input logic [7:0] b);
        logic [7:0] lock_ofs;
        int         i;
        case (phase_m)
            PH_SYNC: begin
                if (b == HDR_SECOND) begin
                    phase_m = PH_FUNC;
                    sum_m   = sum_m + b;
                end else begin
                    phase_m = PH_HUNT;
                end
            end
            PH_FUNC: begin
                if (b != 8'h00 && b < FUNC_LIMIT) begin
                    phase_m = PH_LEN;
                    func_m  = b;
                    sum_m   = sum_m + b;
                end else begin
                    phase_m = PH_HUNT;
                end
            end
            PH_LEN: begin
                if (b < LENGTH_LIMIT) begin
                    phase_m = PH_DATA;
                    left_m  = b[5:0];
                    count_m = '0;
                    sum_m   = sum_m + b;
                end else begin
                    phase_m = PH_HUNT;
                end
            end
            PH_DATA: begin
                // zero length: this byte only ends the frame
                if (left_m != '0) begin
                    store_m[count_m] = b;
                    count_m = count_m + 6'd1;
                    left_m  = left_m - 6'd1;
                    sum_m   = sum_m + b;
                    if (left_m == '0) phase_m = PH_SUM;
                end else begin
                    phase_m = PH_HUNT;
                end
            end
            PH_SUM: begin
                phase_m = PH_HUNT;
                if (sum_m == b) begin
                    // decode reads the store as is, stale entries included
                    if (func_m == CMD_LOCK) begin
                        lock_ofs = store_m[0] - LOCK_CODE_BASE;
                        if (lock_ofs < LOCK_CODES)
                            due_result(t_kind'(lock_ofs[2:0]), 4'd0, 16'h0000, 1'b1);
                    end else if (func_m == CMD_ENABLE) begin
                        for (i = 0; i <= int'(ENABLE_LAST); i++)
                            due_result(KIND_ENABLE, 4'(i), {8'h00, store_m[i]},
                                       i == int'(ENABLE_LAST));
                    end else if (func_m == CMD_GAIN_A) begin
                        for (i = 0; i <= int'(GAIN_A_LAST); i++)
                            due_result(KIND_GAIN_A, 4'(i), {store_m[2*i], store_m[2*i+1]},
                                       i == int'(GAIN_A_LAST));
                    end else if (func_m == CMD_GAIN_B) begin
                        for (i = 0; i <= int'(GAIN_B_LAST); i++)
                            due_result(KIND_GAIN_B, 4'(i), {store_m[2*i], store_m[2*i+1]},
                                       i == int'(GAIN_B_LAST));
                    end
                end
            end
            default: begin
                // hunt, and any unused phase code
                if (b == HDR_FIRST) begin
                    phase_m = PH_SYNC;
                    sum_m   = b;
                end else begin
                    phase_m = PH_HUNT;
                end
            end
        endcase
    endfunction

    // input idle time: mostly back to back, some short gaps, rare long ones
    function automatic int gap_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 9);
        return $urandom_range(15, 30);
    endfunction

    // put a byte on the bus at a falling edge, after an optional idle gap
    task automatic present_byte(input logic [7:0] b, input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
    endtask

    // a transfer happens at the first rising edge with stall low
    task automatic wait_accept();
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // results of a sum byte only appear after its transfer, so the
    // expectation can be queued as soon as the byte is driven
    task automatic send_byte(input logic [7:0] b);
        present_byte(b, gap_len());
        decode_rx_byte(b);
        wait_accept();
    endtask

    // mostly well-formed frames with random content; some are broken on purpose
    task automatic send_random_frame();
        logic [7:0] frame_bytes [$];
        logic [7:0] fn;
        logic [7:0] acc;
        int         r;
        int         len;
        int         i;
        int         n_noise;
        r = $urandom_range(0, 99);
        if (r < 20)      fn = CMD_LOCK;
        else if (r < 40) fn = CMD_ENABLE;
        else if (r < 60) fn = CMD_GAIN_A;
        else if (r < 75) fn = CMD_GAIN_B;
        else             fn = 8'($urandom_range(0, 255));

        // short payloads dominate, the longest legal one shows up now and then
        r = $urandom_range(0, 99);
        if (r < 70)      len = $urandom_range(1, 12);
        else if (r < 85) len = $urandom_range(13, 20);
        else if (r < 93) len = $urandom_range(21, 48);
        else if (r < 98) len = int'(LENGTH_LIMIT) - 1;
        else             len = 0;

        frame_bytes = '{HDR_FIRST, HDR_SECOND, fn, 8'(len)};
        for (i = 0; i < len; i++) begin
            if (i == 0 && fn == CMD_LOCK && $urandom_range(0, 4) != 0)
                frame_bytes.push_back(LOCK_CODE_BASE + 8'($urandom_range(0, LOCK_CODES - 1)));
            else
                frame_bytes.push_back(8'($urandom_range(0, 255)));
        end

        acc = 8'h00;
        foreach (frame_bytes[k]) acc = acc + frame_bytes[k];
        if ($urandom_range(0, 99) < 8) acc = acc ^ 8'($urandom_range(1, 255));
        frame_bytes.push_back(acc);

        // corrupt one byte, or cut the frame short
        if ($urandom_range(0, 99) < 10)
            frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 5)
            repeat ($urandom_range(1, frame_bytes.size() - 1)) void'(frame_bytes.pop_back());

        // some frames go through without a single idle cycle
        no_idle = ($urandom_range(0, 3) == 0);
        foreach (frame_bytes[k]) send_byte(frame_bytes[k]);
        n_frame_items += frame_bytes.size();

        // line noise between frames
        if ($urandom_range(0, 99) < 20) begin
            n_noise = $urandom_range(1, 3);
            repeat (n_noise) send_byte(8'($urandom_range(0, 255)));
            n_frame_items += n_noise;
        end
    endtask

    // result checker: every transfer on the output is matched with the oldest due result
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_results.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected result: kind %0d index %0d value %0d last %0d",
                             o_kind, o_item_index, o_item_value, o_last);
            end else begin
                seen_result = due_results.pop_front();
                if (o_kind !== seen_result.kind || o_item_index !== seen_result.idx ||
                    o_item_value !== seen_result.value || o_last !== seen_result.last) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display({"result mismatch: kind %0d/%0d index %0d/%0d ",
                                  "value %0d/%0d last %0d/%0d (expected/actual)"},
                                 seen_result.kind, o_kind, seen_result.idx, o_item_index,
                                 seen_result.value, o_item_value, seen_result.last, o_last);
                end
            end
        end
    end

    // hold the output stall at one level for a number of cycles
    task automatic out_stall_for(input logic level, input int cycles);
        @(negedge i_clk);
        i_out_stall <= level;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // output back-pressure: quiet stretches, short stalls, rare long stalls
    initial begin : out_stall_gen
        int r;
        @(posedge i_rst_n);
        forever begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                out_stall_for(1'b0, $urandom_range(20, 60));
            end else begin
                if (r < 90) out_stall_for(1'b1, $urandom_range(1, 3));
                else        out_stall_for(1'b1, $urandom_range(10, 30));
                out_stall_for(1'b0, $urandom_range(1, 6));
            end
        end
    end

    // reset, directed table, random frames, drain and verdict
    initial begin : main_seq
        logic [7:0] b;
        int         n_due;
        phase_m = PH_HUNT;
        func_m  = 8'h00;
        left_m  = '0;
        count_m = '0;
        sum_m   = 8'h00;
        foreach (store_m[k]) store_m[k] = 8'h00;
        error_count   = 0;
        n_frame_items = 0;
        no_idle       = 1'b0;

        // synchronous reset held, then released at a falling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows; a typed-in result replaces the computed one
        foreach (DIRECTED_ROWS[k]) begin
            case (DIRECTED_ROWS[k].what)
                ROW_SUM_GOOD: b = sum_m;
                ROW_SUM_BAD:  b = ~sum_m;
                default:      b = DIRECTED_ROWS[k].data;
            endcase
            present_byte(b, gap_len());
            n_due = due_results.size();
            decode_rx_byte(b);
            if (DIRECTED_ROWS[k].fixed_want) begin
                while (due_results.size() > n_due) void'(due_results.pop_back());
                due_results.push_back(DIRECTED_ROWS[k].want);
            end
            wait_accept();
        end

        while (n_frame_items < RANDOM_ITEMS) send_random_frame();

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // let every owed result come out, then watch for strays
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && due_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
+incdir+hdl
hdl/sc8fp_pkg.sv
hdl/sc8fp_ram.sv
hdl/sc8fp_store.sv
hdl/sc8fp_parse.sv
hdl/sc8fp_emit.sv
hdl/sum8_command_frame_parser_top.sv
verif/sum8_command_frame_parser_top_test.sv
